// ===== rtl/tpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tpm_pkg
// Shared types and constants for the trigger primitive time matcher.
// ----------------------------------------------------------------------------
package tpm_pkg;

    // Store geometry and match limit
    localparam int STORE_DEPTH = 1024;
    localparam int MAX_MATCHES = 16;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PTR_W       = $clog2(STORE_DEPTH + 1);
    localparam int MCNT_W      = $clog2(MAX_MATCHES + 1);

    // Field widths; a combined time is {time_stamp, fine_time}
    localparam int TS_W  = 32;
    localparam int FT_W  = 8;
    localparam int ENT_W = TS_W + FT_W;
    localparam int WIN_W = 20;
    localparam int CMD_W = 2;
    localparam int ST_W  = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSEST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WINDOW  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_IGNORE  = 2'd3;

    // Result status codes
    localparam logic [ST_W-1:0] ST_MATCH   = 3'd0;
    localparam logic [ST_W-1:0] ST_NOMATCH = 3'd1;
    localparam logic [ST_W-1:0] ST_LOADED  = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
    localparam logic [ST_W-1:0] ST_TRUNC   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [TS_W-1:0]  time_stamp;
        logic [FT_W-1:0]  fine_time;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [TS_W-1:0] prim_time_stamp;
        logic [FT_W-1:0] prim_fine_time;
        logic            last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic            accept;      // latch the input item
        logic            tgt_lo;      // scan target is the lower window edge
        logic            ptr_inc;     // step pointer forward, read next entry
        logic            ptr_dec;     // step pointer back by one
        logic            rd_prev;     // read the entry before the pointer
        logic            load_wr;     // append latched primitive
        logic            cand_ld_ent; // candidate from delayed entry and distance
        logic            cand_ld_rd;  // candidate from current read data
        logic            emit;        // write the output register
        logic [ST_W-1:0] emit_status;
        logic            emit_data;   // payload from candidate, else zero
        logic            emit_last;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic ptr_lt_fill;
        logic ptr_nz;
        logic full;
        logic ent_lt_tgt;
        logic ent_le_hi;
        logic dist_lt_cand;
        logic cand_in_win;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/tpm_dp.sv =====
// ----------------------------------------------------------------------------
// tpm_dp
// Datapath: primitive store, fill count, read pointer, window register,
// distance and candidate registers, and the output register.
// ----------------------------------------------------------------------------
module tpm_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tpm_pkg::t_in_item            i_in_item,
    input  logic                         i_cfg_wr_en,
    input  logic [tpm_pkg::WIN_W-1:0]    i_cfg_wr_data,
    input  tpm_pkg::t_dp_cmd             i_cmd,
    output tpm_pkg::t_dp_stat            o_stat,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output tpm_pkg::t_out_item           o_out_item
);
    import tpm_pkg::*;

    logic [ENT_W-1:0] r_mem [STORE_DEPTH];

    logic [PTR_W-1:0] r_fill;
    logic [PTR_W-1:0] r_ptr;
    logic [WIN_W-1:0] r_window;
    logic [ENT_W-1:0] r_ev;
    logic [ENT_W-1:0] r_tgt;
    logic [ENT_W:0]   r_hi;
    logic [ENT_W-1:0] r_rdata;
    logic [ENT_W-1:0] r_ent;
    logic [ENT_W-1:0] r_dist;
    logic [ENT_W-1:0] r_cand;
    logic [ENT_W-1:0] r_dcand;
    t_out_item        r_out;
    logic             r_out_valid;

    logic [ENT_W-1:0] w_in_time;
    logic [ENT_W-1:0] w_win_ext;
    logic [ENT_W-1:0] w_lo;
    logic [ENT_W-1:0] w_dist;
    logic [PTR_W-1:0] w_rd_ptr;

    // Event time and window edges of the incoming item
    assign w_in_time = {i_in_item.time_stamp, i_in_item.fine_time};
    assign w_win_ext = ENT_W'(r_window);
    assign w_lo      = (w_in_time >= w_win_ext) ? (w_in_time - w_win_ext) : '0;

    // Distance of the entry just read from the event time
    assign w_dist = (r_rdata >= r_ev) ? (r_rdata - r_ev) : (r_ev - r_rdata);

    // Read address follows the pointer step of this cycle, or the entry before the pointer
    always_comb begin
        if (i_cmd.ptr_inc) begin
            w_rd_ptr = r_ptr + PTR_W'(1);
        end else if (i_cmd.rd_prev) begin
            w_rd_ptr = r_ptr - PTR_W'(1);
        end else begin
            w_rd_ptr = r_ptr;
        end
    end

    // Primitive store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_mem[r_fill[ADDR_W-1:0]] <= r_ev;
        end
        r_rdata <= r_mem[w_rd_ptr[ADDR_W-1:0]];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ent  <= r_rdata;
        r_dist <= w_dist;
        if (i_cmd.accept) begin
            r_ev  <= w_in_time;
            r_tgt <= i_cmd.tgt_lo ? w_lo : w_in_time;
            r_hi  <= {1'b0, w_in_time} + (ENT_W + 1)'(r_window);
        end
        if (i_cmd.cand_ld_ent) begin
            r_cand  <= r_ent;
            r_dcand <= r_dist;
        end else if (i_cmd.cand_ld_rd) begin
            r_cand <= r_rdata;
        end
        if (i_cmd.emit) begin
            r_out.status <= i_cmd.emit_status;
            r_out.last   <= i_cmd.emit_last;
            if (i_cmd.emit_data) begin
                r_out.prim_time_stamp <= r_cand[ENT_W-1:FT_W];
                r_out.prim_fine_time  <= r_cand[FT_W-1:0];
            end else begin
                r_out.prim_time_stamp <= '0;
                r_out.prim_fine_time  <= '0;
            end
        end
    end

    // Control registers: fill count, pointer, window, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_ptr       <= '0;
            r_window    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (i_cmd.load_wr) begin
                r_fill <= r_fill + PTR_W'(1);
            end
            if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + PTR_W'(1);
            end else if (i_cmd.ptr_dec) begin
                r_ptr <= r_ptr - PTR_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.ptr_lt_fill  = (r_ptr < r_fill);
        o_stat.ptr_nz       = (r_ptr != '0);
        o_stat.full         = (r_fill == PTR_W'(STORE_DEPTH));
        o_stat.ent_lt_tgt   = (r_rdata < r_tgt);
        o_stat.ent_le_hi    = ({1'b0, r_rdata} <= r_hi);
        o_stat.dist_lt_cand = (r_dist < r_dcand);
        o_stat.cand_in_win  = (r_dcand <= w_win_ext);
        o_stat.out_free     = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/tpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpm_ctrl
// Controller: sequences loads, the pointer scan, the closest-match decision
// and the window walk, and issues datapath commands.
// ----------------------------------------------------------------------------
module tpm_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [tpm_pkg::CMD_W-1:0] i_in_cmd,
    input  tpm_pkg::t_dp_stat         i_stat,
    output tpm_pkg::t_dp_cmd          o_cmd
);
    import tpm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_CL_CUR,
        S_CL_PREV,
        S_CL_DECIDE,
        S_WIN
    } t_state;

    t_state            r_state, n_state;
    logic              r_is_win, n_is_win;
    logic [MCNT_W-1:0] r_n, n_n;
    logic              r_have, n_have;
    logic              r_pick_prev, n_pick_prev;

    logic w_take_prev;
    logic w_in_win;
    logic w_at_max;
    logic w_final;

    // no item is taken while in reset
    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign w_take_prev = i_stat.ptr_nz && (!i_stat.ptr_lt_fill || i_stat.dist_lt_cand);
    assign w_in_win    = i_stat.ptr_lt_fill && i_stat.ent_le_hi;
    assign w_at_max    = (r_n == MCNT_W'(MAX_MATCHES));
    assign w_final     = !w_in_win || w_at_max;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_is_win    = r_is_win;
        n_n         = r_n;
        n_have      = r_have;
        n_pick_prev = r_pick_prev;
        o_cmd       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.tgt_lo = (i_in_cmd == CMD_WINDOW);
                    n_is_win     = (i_in_cmd == CMD_WINDOW);
                    n_n          = '0;
                    unique case (i_in_cmd)
                        CMD_LOAD:    n_state = S_LOAD;
                        CMD_CLOSEST: n_state = S_SCAN;
                        CMD_WINDOW:  n_state = S_SCAN;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end

            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.load_wr     = !i_stat.full;
                    o_cmd.emit_status = i_stat.full ? ST_FULL : ST_LOADED;
                    n_state           = S_IDLE;
                end
            end

            // Skip entries before the target, one per cycle
            S_SCAN: begin
                if (i_stat.ptr_lt_fill && i_stat.ent_lt_tgt) begin
                    o_cmd.ptr_inc = 1'b1;
                end else if (r_is_win) begin
                    n_state = S_WIN;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_CL_CUR;
                end
            end

            // Entry at the pointer becomes the candidate
            S_CL_CUR: begin
                o_cmd.cand_ld_ent = i_stat.ptr_lt_fill;
                n_state           = S_CL_PREV;
            end

            // Previous entry wins when strictly nearer or when at end of store
            S_CL_PREV: begin
                o_cmd.cand_ld_ent = w_take_prev;
                n_have            = i_stat.ptr_lt_fill || i_stat.ptr_nz;
                n_pick_prev       = w_take_prev;
                n_state           = S_CL_DECIDE;
            end

            S_CL_DECIDE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    if (r_have && i_stat.cand_in_win) begin
                        o_cmd.emit_status = ST_MATCH;
                        o_cmd.emit_data   = 1'b1;
                        o_cmd.ptr_dec     = r_pick_prev;
                    end else begin
                        o_cmd.emit_status = ST_NOMATCH;
                    end
                    n_state = S_IDLE;
                end
            end

            // Walk the window; a pending item goes out once its successor is known
            S_WIN: begin
                if (r_n == '0) begin
                    if (w_in_win) begin
                        o_cmd.cand_ld_rd = 1'b1;
                        o_cmd.ptr_inc    = 1'b1;
                        n_n              = MCNT_W'(1);
                    end else if (i_stat.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_last   = 1'b1;
                        o_cmd.emit_status = ST_NOMATCH;
                        n_state           = S_IDLE;
                    end
                end else if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_data   = 1'b1;
                    o_cmd.emit_last   = w_final;
                    o_cmd.emit_status = (w_in_win && w_at_max) ? ST_TRUNC : ST_MATCH;
                    if (w_final) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.cand_ld_rd = 1'b1;
                        o_cmd.ptr_inc    = 1'b1;
                        n_n              = r_n + MCNT_W'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_is_win    <= 1'b0;
            r_n         <= '0;
            r_have      <= 1'b0;
            r_pick_prev <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_is_win    <= n_is_win;
            r_n         <= n_n;
            r_have      <= n_have;
            r_pick_prev <= n_pick_prev;
        end
    end

endmodule

// ===== rtl/trigger_primitive_time_matcher.sv =====
// ----------------------------------------------------------------------------
// trigger_primitive_time_matcher: closest and window queries scan past skipped
// entries, one store read a cycle, and window then reports its entries. One item
// at a time; next item taken once the last result is issued. Reset (sync, active
// low) clears fill count, pointer, window; store not cleared.
// ----------------------------------------------------------------------------
module trigger_primitive_time_matcher (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  tpm_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output tpm_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_wr_en,
    input  logic [tpm_pkg::WIN_W-1:0] i_cfg_wr_data
);
    import tpm_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Controller
    tpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_cmd   (i_in_item.command),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath
    tpm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_item     (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_item    (o_out_item)
    );

`ifndef SYNTHESIS
    // Non-match results carry no primitive
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_MATCH && o_out_item.status != ST_TRUNC
        |-> o_out_item.prim_time_stamp == '0 && o_out_item.prim_fine_time == '0)
        else $error("non-match result with nonzero primitive");

    // Every status but a plain match ends the item
    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_MATCH |-> o_out_item.last)
        else $error("terminal status without last");

    // A working command blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.command != CMD_IGNORE |=> o_in_stall)
        else $error("input not stalled while item in work");
`endif

endmodule

// ===== verif/trigger_primitive_time_matcher_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trigger_primitive_time_matcher_tb
// Self-checking bench for the time matcher. A shadow copy of the primitive
// store, fill count, read pointer and window predicts every result of each
// accepted item. A checker process compares each result field by field with
// the oldest prediction. Directed cases come first: empty store, nearest pick
// and ties, end of store, fine-time wrap, truncation and window saturation.
// Random traffic follows with time-ordered loads and queries near them, under
// several window settings. The last part loads a run of primitives at the
// largest time. The sender runs in bursts and the receiver stalls on its own
// pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module trigger_primitive_time_matcher_tb;
    import tpm_pkg::*;

    localparam int CLK_HALF_NS   = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_PRINTED   = 40;
    localparam int RECENT_DEPTH  = 32;
    localparam logic [ENT_W-1:0] TIME_MAX = '1;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} t_stall_mode;

    // DUT ports, all driven from time zero
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_in_valid    = 1'b0;
    t_in_item         i_in_item     = '0;
    logic             i_out_stall   = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic [WIN_W-1:0] i_cfg_wr_data = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out_item        o_out_item;

    // Shadow state of the matcher
    logic [ENT_W-1:0] shadow_store [STORE_DEPTH];
    int unsigned      shadow_fill   = 0;
    int unsigned      shadow_ptr    = 0;
    logic [WIN_W-1:0] shadow_window = '0;
    t_out_item        pending_results [$];

    // Stimulus bookkeeping
    logic [ENT_W-1:0] time_cursor = '0;
    logic [ENT_W-1:0] recent_loads [$];
    bit               sender_active = 1'b0;
    int unsigned      burst_left    = 0;
    int unsigned      gap_left      = 1;

    // Receiver stall control
    logic             long_hold_req      = 1'b0;
    logic             long_hold_ack      = 1'b0;
    int unsigned      hold_left          = 0;
    int unsigned      stall_segment_left = 0;
    t_stall_mode      stall_mode         = STALL_NONE;

    // Run statistics
    int unsigned error_count     = 0;
    int unsigned results_seen    = 0;
    int unsigned items_accepted  = 0;
    int unsigned match_count     = 0;
    int unsigned trunc_count     = 0;
    int unsigned nomatch_count   = 0;
    int unsigned dropped_count   = 0;
    int unsigned window_settings = 0;
    int unsigned cycle_count     = 0;

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    trigger_primitive_time_matcher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic t_out_item make_result(logic [ST_W-1:0] status,
                                              logic [ENT_W-1:0] entry, logic last);
        t_out_item r;
        r.status          = status;
        r.prim_time_stamp = entry[ENT_W-1:FT_W];
        r.prim_fine_time  = entry[FT_W-1:0];
        r.last            = last;
        return r;
    endfunction

    function automatic logic [ENT_W-1:0] time_gap(logic [ENT_W-1:0] a,
                                                  logic [ENT_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Appends one expected result at the tail of the queue
    function automatic void queue_result(t_out_item r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Works out the results of one accepted item and updates the shadow state
    function automatic void predict_match_results(t_in_item item);
        logic [ENT_W-1:0] ev;
        logic [ENT_W-1:0] win;
        logic [ENT_W-1:0] lo;
        logic [ENT_W:0]   hi;
        int unsigned      pick;
        int               n;
        t_out_item        tail;
        ev  = {item.time_stamp, item.fine_time};
        win = ENT_W'(shadow_window);
        case (item.command)
            CMD_LOAD: begin
                if (shadow_fill < STORE_DEPTH) begin
                    shadow_store[shadow_fill] = ev;
                    shadow_fill++;
                    queue_result(make_result(ST_LOADED, '0, 1'b1));
                end else begin
                    queue_result(make_result(ST_FULL, '0, 1'b1));
                end
            end
            CMD_CLOSEST: begin
                while (shadow_ptr < shadow_fill && shadow_store[shadow_ptr] < ev)
                    shadow_ptr++;
                if (shadow_fill == 0) begin
                    queue_result(make_result(ST_NOMATCH, '0, 1'b1));
                end else begin
                    // nearer of pointer entry and the one before; tie keeps the later
                    if (shadow_ptr < shadow_fill) begin
                        pick = shadow_ptr;
                        if (shadow_ptr > 0 &&
                            time_gap(shadow_store[shadow_ptr - 1], ev) <
                            time_gap(shadow_store[shadow_ptr], ev))
                            pick = shadow_ptr - 1;
                    end else begin
                        pick = shadow_fill - 1;
                    end
                    if (time_gap(shadow_store[pick], ev) <= win) begin
                        shadow_ptr = pick;
                        queue_result(make_result(ST_MATCH, shadow_store[pick], 1'b1));
                    end else begin
                        queue_result(make_result(ST_NOMATCH, '0, 1'b1));
                    end
                end
            end
            CMD_WINDOW: begin
                // lower edge saturates at zero, upper edge carries one extra bit
                lo = (ev >= win) ? ev - win : '0;
                hi = {1'b0, ev} + {1'b0, win};
                while (shadow_ptr < shadow_fill && shadow_store[shadow_ptr] < lo)
                    shadow_ptr++;
                n = 0;
                while (n < MAX_MATCHES && shadow_ptr < shadow_fill &&
                       {1'b0, shadow_store[shadow_ptr]} <= hi) begin
                    queue_result(make_result(ST_MATCH, shadow_store[shadow_ptr], 1'b0));
                    shadow_ptr++;
                    n++;
                end
                if (n == 0) begin
                    queue_result(make_result(ST_NOMATCH, '0, 1'b1));
                end else begin
                    tail = pending_results.pop_back();
                    if (shadow_ptr < shadow_fill && {1'b0, shadow_store[shadow_ptr]} <= hi)
                        tail.status = ST_TRUNC;
                    tail.last = 1'b1;
                    queue_result(tail);
                end
            end
            default: ;  // unused command: no result, no state change
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d ts %h ft %h last %b",
                    o_out_item.status, o_out_item.prim_time_stamp,
                    o_out_item.prim_fine_time, o_out_item.last));
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.status !== want.status ||
                    o_out_item.prim_time_stamp !== want.prim_time_stamp ||
                    o_out_item.prim_fine_time !== want.prim_fine_time ||
                    o_out_item.last !== want.last)
                    report_mismatch($sformatf(
                        "result %0d got st %0d ts %h ft %h last %b, want st %0d ts %h ft %h last %b",
                        results_seen, o_out_item.status, o_out_item.prim_time_stamp,
                        o_out_item.prim_fine_time, o_out_item.last, want.status,
                        want.prim_time_stamp, want.prim_fine_time, want.last));
                case (want.status)
                    ST_MATCH:   match_count++;
                    ST_TRUNC:   trunc_count++;
                    ST_NOMATCH: nomatch_count++;
                    ST_FULL:    dropped_count++;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall: random modes in segments, plus one long hold on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (long_hold_req != long_hold_ack) begin
            long_hold_ack <= long_hold_req;
            hold_left     <= LONG_HOLD - 1;
            i_out_stall   <= 1'b1;
        end else begin
            if (stall_segment_left == 0) begin
                stall_mode         <= t_stall_mode'($urandom_range(0, 3));
                stall_segment_left <= $urandom_range(10, 120);
            end else begin
                stall_segment_left <= stall_segment_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 99) < 25);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 99) < 70);
                default:     i_out_stall <= (stall_segment_left[1:0] != 2'd0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Item sender and configuration
    // ------------------------------------------------------------------------
    // Offers one item, waits for acceptance; bursts end in a random gap
    task automatic offer_item(logic [CMD_W-1:0] cmd, logic [ENT_W-1:0] t);
        t_in_item item;
        item.command    = cmd;
        item.time_stamp = t[ENT_W-1:FT_W];
        item.fine_time  = t[FT_W-1:0];
        if (!sender_active) begin
            repeat (gap_left) @(posedge i_clk);
            i_in_valid    <= 1'b1;
            sender_active = 1'b1;
            burst_left    = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                                                         : $urandom_range(20, 60);
        end
        i_in_item <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_accepted++;
        predict_match_results(item);
        burst_left--;
        if (burst_left == 0) begin
            i_in_valid    <= 1'b0;
            sender_active = 1'b0;
            gap_left      = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4)
                                                         : $urandom_range(5, 30);
        end
    endtask

    // Stops offering, waits for all results and lets the block go quiet
    task automatic settle_idle;
        if (sender_active) begin
            i_in_valid    <= 1'b0;
            sender_active = 1'b0;
            gap_left      = 1;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(logic [WIN_W-1:0] value);
        settle_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        shadow_window = value;
        window_settings++;
    endtask

    // Appends a primitive a random step after the previous one
    task automatic load_next(int unsigned step_max);
        logic [ENT_W:0] next;
        next        = {1'b0, time_cursor} + (ENT_W + 1)'($urandom_range(1, step_max));
        time_cursor = next[ENT_W] ? TIME_MAX : next[ENT_W-1:0];
        recent_loads.insert(recent_loads.size(), time_cursor);
        if (recent_loads.size() > RECENT_DEPTH) void'(recent_loads.pop_front());
        offer_item(CMD_LOAD, time_cursor);
    endtask

    // Mostly ordered loads and queries around recent primitives, some noise
    task automatic random_traffic(int unsigned n_items, int unsigned step_max);
        int unsigned      made;
        int unsigned      roll;
        int unsigned      off;
        logic [ENT_W-1:0] base;
        logic [ENT_W-1:0] ev;
        logic [ENT_W:0]   wide;
        made = 0;
        while (made < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 50 || recent_loads.size() == 0) begin
                load_next(step_max);
                made++;
            end else if (roll < 90) begin
                base = recent_loads[$urandom_range(0, recent_loads.size() - 1)];
                off  = $urandom_range(0, shadow_window + step_max);
                if ($urandom_range(0, 1)) begin
                    wide = {1'b0, base} + (ENT_W + 1)'(off);
                    ev   = wide[ENT_W] ? TIME_MAX : wide[ENT_W-1:0];
                end else begin
                    ev = (base >= ENT_W'(off)) ? base - ENT_W'(off) : '0;
                end
                offer_item((roll < 70) ? CMD_CLOSEST : CMD_WINDOW, ev);
                made++;
            end else if (roll < 94) begin
                // load slightly behind the newest primitive
                off = $urandom_range(1, step_max);
                offer_item(CMD_LOAD, (time_cursor >= ENT_W'(off)) ?
                                     time_cursor - ENT_W'(off) : '0);
                made++;
            end else if (roll < 97) begin
                ev = {$urandom(), 8'($urandom_range(0, 255))};
                offer_item($urandom_range(0, 1) ? CMD_CLOSEST : CMD_WINDOW, ev);
                made++;
            end else begin
                offer_item(CMD_IGNORE, {$urandom(), 8'($urandom_range(0, 255))});
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_empty_store;
        // window still at its reset value of zero
        offer_item(CMD_CLOSEST, '0);
        offer_item(CMD_WINDOW, '0);
        offer_item(CMD_IGNORE, TIME_MAX);
        offer_item(CMD_LOAD, '0);
        // only one candidate with the pointer at entry zero
        offer_item(CMD_CLOSEST, '0);
    endtask

    task automatic test_closest_pick;
        set_window(WIN_W'(600));
        offer_item(CMD_LOAD, {32'd10, 8'd255});
        offer_item(CMD_LOAD, {32'd11, 8'd0});
        offer_item(CMD_LOAD, {32'd20, 8'd0});
        offer_item(CMD_LOAD, {32'd22, 8'd0});
        offer_item(CMD_LOAD, {32'd35, 8'd40});
        // exact hit across the fine-time wrap
        offer_item(CMD_CLOSEST, {32'd11, 8'd0});
        // nearest lies outside the window
        offer_item(CMD_CLOSEST, {32'd15, 8'd160});
        // tie between neighbors goes to the later one
        offer_item(CMD_CLOSEST, {32'd21, 8'd0});
        // earlier neighbor wins, pointer steps back
        offer_item(CMD_CLOSEST, {32'd20, 8'd180});
        // past the end: last primitive inside, then outside the window
        offer_item(CMD_CLOSEST, {32'd37, 8'd28});
        offer_item(CMD_CLOSEST, {32'd78, 8'd32});
    endtask

    task automatic test_window_report;
        set_window(WIN_W'(1024));
        for (int i = 0; i <= MAX_MATCHES; i++)
            offer_item(CMD_LOAD, ENT_W'(30000 + 10 * i));
        // one more than the limit lies in the window: truncated, then the rest
        offer_item(CMD_WINDOW, ENT_W'(30100));
        offer_item(CMD_WINDOW, ENT_W'(30100));
        offer_item(CMD_WINDOW, ENT_W'(30100));
        // widest window reaching below time zero
        set_window('1);
        offer_item(CMD_LOAD, ENT_W'(50000));
        offer_item(CMD_WINDOW, ENT_W'(100));
    endtask

    task automatic test_random_traffic;
        time_cursor = ENT_W'(60000);
        // moderate window over closely spaced primitives
        set_window(WIN_W'($urandom_range(64, 4000)));
        random_traffic(32, 600);
        // zero window, only exact hits; receiver holds off at the start
        set_window('0);
        long_hold_req <= ~long_hold_req;
        random_traffic(32, 8);
        // widest window, window queries mostly truncate
        set_window('1);
        random_traffic(32, 40000);
        // any window, any spacing
        set_window(WIN_W'($urandom_range(0, (1 << WIN_W) - 1)));
        random_traffic(32, $urandom_range(16, 100000));
        // near the top of the time range
        time_cursor = {32'hFFFF_F000, 8'h00};
        recent_loads.delete();
        set_window(WIN_W'($urandom_range(256, 20000)));
        random_traffic(32, 3000);
    endtask

    task automatic test_time_top;
        set_window(WIN_W'(4096));
        // a run of entries at the largest time
        repeat (MAX_MATCHES + 2) offer_item(CMD_LOAD, TIME_MAX);
        offer_item(CMD_CLOSEST, TIME_MAX);
        // upper window edge beyond the time range
        offer_item(CMD_WINDOW, TIME_MAX);
        offer_item(CMD_WINDOW, TIME_MAX);
        offer_item(CMD_WINDOW, TIME_MAX);
    endtask

    // ------------------------------------------------------------------------
    // Sequence and end of run
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_store();
        test_closest_pick();
        test_window_report();
        test_random_traffic();
        test_time_top();
        settle_idle();
        $display("covered %0d items, %0d results: %0d matches, %0d truncated, %0d no match",
                 items_accepted, results_seen, match_count, trunc_count, nomatch_count);
        $display("store holds %0d entries, %0d loads dropped, %0d window settings",
                 shadow_fill, dropped_count, window_settings);
        if (error_count == 0) begin
            $display("trigger_primitive_time_matcher_tb: done, clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("trigger_primitive_time_matcher_tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("cycle limit reached, %0d results still expected", pending_results.size());
        $display("trigger_primitive_time_matcher_tb: done, errors");
        $finish;
    end

endmodule
